/* design/atb_pkg.sv */
package atb_pkg;

  // Field and register widths
  localparam int PIX_W      = 8;
  localparam int COL_OUT_W  = 11;
  localparam int WIDTH_W    = 12;
  localparam int WLEN_W     = 9;
  localparam int DECAY_W    = 16;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Running sum and column sums are 32-bit unsigned fixed point
  localparam int SUM_W = 32;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Seed grey level and the doubled percent scale used by the threshold test
  localparam int SEED_LEVEL = 127;
  localparam int PCT_SCALE  = 200;

  // Register defaults
  localparam logic [WIDTH_W-1:0] WIDTH_RST = 12'd640;
  localparam logic [WLEN_W-1:0]  WLEN_RST  = 9'd80;
  localparam logic [DECAY_W-1:0] DECAY_RST = 16'd64717;
  localparam logic [PCT_W-1:0]   PCT_RST   = 7'd63;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_WINDOW_LEN    = 2'd1,
    REG_DECAY_COEFF   = 2'd2,
    REG_THRESHOLD_PCT = 2'd3
  } cfg_reg_t;

  // Request from the pixel sequencer to the scan tracker
  typedef struct packed {
    logic step;
    logic restart;
  } scan_req_t;

endpackage

/* design/atb_pix_if.sv */
interface atb_pix_if;
  import atb_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             start_of_image;

  modport source (output valid, output pixel, output start_of_image, input ready);
  modport sink (input valid, input pixel, input start_of_image, output ready);

endinterface

/* design/atb_res_if.sv */
interface atb_res_if;
  import atb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 is_white;
  logic [COL_OUT_W-1:0] column;

  modport source (output valid, output is_white, output column, input ready);
  modport sink (input valid, input is_white, input column, output ready);

endinterface

/* design/atb_ram.sv */
module atb_ram #(
  parameter int DEPTH  = 2048,
  parameter int DATA_W = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds its data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/atb_scan.sv */
module atb_scan #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [atb_pkg::WIDTH_W-1:0]    image_width,
  input  atb_pkg::scan_req_t             req,
  output logic [$clog2(MAX_WIDTH)-1:0]   col,
  output logic                           first_row
);
  import atb_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CNT_W = COL_W + 1;
  localparam int EXT_W = (CNT_W > WIDTH_W) ? CNT_W : WIDTH_W;

  logic [COL_W-1:0] scan_index;
  logic             odd_row;
  logic             first_flag;

  logic [EXT_W-1:0] w_ext;
  logic [CNT_W-1:0] w_eff;
  logic [CNT_W-1:0] w_m1;
  logic [COL_W-1:0] idx_in;
  logic [COL_W-1:0] idx_sat;
  logic [CNT_W-1:0] idx_inc;
  logic             odd_in;
  logic [COL_W-1:0] scan_index_next;
  logic             odd_row_next;
  logic             first_flag_next;

  // Clamp the row width to 1..MAX_WIDTH
  always_comb begin
    w_ext = EXT_W'(image_width);
    if (w_ext == '0) begin
      w_ext = EXT_W'(1);
    end else if (w_ext > EXT_W'(MAX_WIDTH)) begin
      w_ext = EXT_W'(MAX_WIDTH);
    end
    w_eff = CNT_W'(w_ext);
    w_m1  = w_eff - CNT_W'(1);
  end

  // Position of the current pixel; a start mark restarts the scan
  always_comb begin
    idx_in     = req.restart ? '0 : scan_index;
    odd_in     = req.restart ? 1'b0 : odd_row;
    first_row  = req.restart ? 1'b1 : first_flag;
    idx_sat    = ({1'b0, idx_in} >= w_eff) ? w_m1[COL_W-1:0] : idx_in;
    col        = odd_in ? COL_W'(w_m1 - {1'b0, idx_sat}) : idx_sat;
    idx_inc    = {1'b0, idx_sat} + CNT_W'(1);
    if (idx_inc >= w_eff) begin
      scan_index_next = '0;
      odd_row_next    = ~odd_in;
      first_flag_next = 1'b0;
    end else begin
      scan_index_next = idx_inc[COL_W-1:0];
      odd_row_next    = odd_in;
      first_flag_next = first_row;
    end
  end

  // Advance the scan on every transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_index <= '0;
      odd_row    <= 1'b0;
      first_flag <= 1'b1;
    end else if (req.step) begin
      scan_index <= scan_index_next;
      odd_row    <= odd_row_next;
      first_flag <= first_flag_next;
    end
  end

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    req.step |-> ({1'b0, col} < w_eff))
    else $error("column outside the current row");

  a_first_row_sticky: assert property (@(posedge clk) disable iff (rst)
    (req.step && !req.restart && !first_flag) |=> !first_flag)
    else $error("first row returned without a start mark");

  a_scan_moves_on_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(scan_index) |-> $past(req.step))
    else $error("scan index moved without a transfer");

endmodule

/* design/adaptive_threshold_binarizer.sv */
// Adaptive threshold binarizer for grey pixels in serpentine order (even rows left to
// right, odd rows right to left). The transfer edge of a pixel registers it and issues
// the line buffer read of the previous row's column sum. The pixel then passes these
// steps in order. S_MUL does the 32x16 decay multiply of the running sum. S_ADD adds the
// pixel, writes the new sum back and forms the doubled threshold. S_THR does the percent
// multiply. S_OUT does the final compare into the output register. A new pixel is taken
// only once the sequence is back in S_IDLE, never while one is in flight; the running-sum
// recurrence and the line buffer read-modify-write require this. The next pixel is taken
// as soon as the result sits in the output register, even if the sink has not taken it
// yet; a result still waiting there holds the following pixel in its compare step. The
// line buffer needs no clearing after reset: the first row of every image writes each
// column before any later row reads it. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while no pixel is in flight; the block does not enforce it.
module adaptive_threshold_binarizer #(
  parameter int MAX_WIDTH     = 2048,
  parameter int SUM_FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  atb_pix_if.sink                        pix,
  atb_res_if.source                      res,
  input  logic                           cfg_we,
  input  logic [atb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [atb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import atb_pkg::*;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int PROD_W  = SUM_W + DECAY_W;
  localparam int SEED_BW = PIX_W + WLEN_W - 1;
  localparam int SEED_FW = SEED_BW + SUM_FRAC_BITS;
  localparam int SEED_CW = (SEED_FW > SUM_W + 1) ? SEED_FW : SUM_W + 1;
  localparam int ADD_W   = SUM_W + 1;
  localparam int TWICE_W = SUM_W + 1;
  localparam int RHS_W   = TWICE_W + PCT_W;
  localparam int PS_W    = PIX_W + WLEN_W;
  localparam int LB_W    = PS_W + 8;
  localparam int LHS_W   = LB_W + SUM_FRAC_BITS;
  localparam int CMP_W   = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_THR,
    S_OUT
  } state_t;

  state_t state;

  // Configuration registers
  logic [WIDTH_W-1:0] image_width;
  logic [WLEN_W-1:0]  window_len;
  logic [DECAY_W-1:0] decay_coeff;
  logic [PCT_W-1:0]   threshold_pct;

  // Pixel in flight
  logic [PIX_W-1:0]   pixel_q;
  logic               start_q;
  logic               first_q;
  logic [COL_W-1:0]   col_q;
  logic [PROD_W-1:0]  prod_q;
  logic [PS_W-1:0]    ps_q;
  logic [TWICE_W-1:0] twice_q;
  logic [RHS_W-1:0]   rhs_q;
  logic [LB_W-1:0]    lb_q;
  logic [SUM_W-1:0]   running_sum;

  logic               pix_xfer;
  scan_req_t          scan_req;
  logic [COL_W-1:0]   scan_col;
  logic               scan_first;
  logic [SUM_W-1:0]   col_sum;

  logic [SEED_BW-1:0] seed_base;
  logic [SEED_CW-1:0] seed_full;
  logic [SUM_W-1:0]   seed;
  logic [SUM_W-1:0]   rs_src;
  logic [ADD_W-1:0]   sum_full;
  logic [SUM_W-1:0]   sum_sat;
  logic [TWICE_W-1:0] twice;
  logic [CMP_W-1:0]   lhs;
  logic               black;
  logic               out_free;
  logic               ram_we;

  assign pix.ready = (state == S_IDLE);
  assign pix_xfer  = pix.valid && pix.ready;
  assign out_free  = !res.valid || res.ready;
  assign ram_we    = (state == S_ADD);

  assign scan_req.step    = pix_xfer;
  assign scan_req.restart = pix.start_of_image;

  atb_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
    .clk         (clk),
    .rst         (rst),
    .image_width (image_width),
    .req         (scan_req),
    .col         (scan_col),
    .first_row   (scan_first)
  );

  // Line buffer of column sums from the previous row
  atb_ram #(.DEPTH(MAX_WIDTH), .DATA_W(SUM_W)) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col_q),
    .wdata (sum_sat),
    .re    (pix_xfer),
    .raddr (scan_col),
    .rdata (col_sum)
  );

  // Seed of 127 * window_len in fixed point, saturated
  always_comb begin
    seed_base = SEED_BW'(SEED_LEVEL * window_len);
    seed_full = SEED_CW'(seed_base) << SUM_FRAC_BITS;
    seed      = (seed_full > SEED_CW'(SUM_MAX)) ? SUM_MAX : seed_full[SUM_W-1:0];
    rs_src    = start_q ? seed : running_sum;
  end

  // Decayed sum plus pixel, saturated; doubled threshold from row above
  always_comb begin
    sum_full = ADD_W'(prod_q[PROD_W-1:DECAY_W]) + (ADD_W'(pixel_q) << SUM_FRAC_BITS);
    sum_sat  = sum_full[ADD_W-1] ? SUM_MAX : sum_full[SUM_W-1:0];
    if (first_q) begin
      twice = {sum_sat, 1'b0};
    end else begin
      twice = TWICE_W'(sum_sat) + TWICE_W'(col_sum);
    end
  end

  // Black when pixel * s * 200 * 2^F < 2 * threshold * percent
  always_comb begin
    lhs   = CMP_W'(lb_q) << SUM_FRAC_BITS;
    black = lhs < CMP_W'(rhs_q);
  end

  // Datapath registers of the pixel in flight
  always_ff @(posedge clk) begin
    if (pix_xfer) begin
      pixel_q <= pix.pixel;
      start_q <= pix.start_of_image;
      first_q <= scan_first;
      col_q   <= scan_col;
    end
    if (state == S_MUL) begin
      prod_q <= PROD_W'(rs_src) * PROD_W'(decay_coeff);
      ps_q   <= PS_W'(pixel_q) * PS_W'(window_len);
    end
    if (state == S_ADD) begin
      twice_q <= twice;
    end
    if (state == S_THR) begin
      rhs_q <= RHS_W'(twice_q) * RHS_W'(threshold_pct);
      lb_q  <= LB_W'(ps_q) * LB_W'(PCT_SCALE);
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= WIDTH_RST;
      window_len    <= WLEN_RST;
      decay_coeff   <= DECAY_RST;
      threshold_pct <= PCT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[WIDTH_W-1:0];
        REG_WINDOW_LEN:    window_len    <= cfg_data[WLEN_W-1:0];
        REG_DECAY_COEFF:   decay_coeff   <= cfg_data[DECAY_W-1:0];
        REG_THRESHOLD_PCT: threshold_pct <= cfg_data[PCT_W-1:0];
      endcase
    end
  end

  // Sequencer, running sum and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      running_sum <= '0;
      res.valid   <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pix_xfer) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_ADD;
        end
        S_ADD: begin
          running_sum <= sum_sat;
          state       <= S_THR;
        end
        S_THR: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            res.valid    <= 1'b1;
            res.is_white <= !black;
            res.column   <= COL_OUT_W'(col_q);
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_xfer_starts_item: assert property (@(posedge clk) disable iff (rst)
    pix_xfer |=> (state == S_MUL) && !pix.ready)
    else $error("pixel transfer did not start the sequence");

  a_result_from_compare: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state == S_OUT))
    else $error("result raised outside the compare step");

  a_sum_updates_once: assert property (@(posedge clk) disable iff (rst)
    !$stable(running_sum) |-> $past(state == S_ADD))
    else $error("running sum changed outside the update step");

endmodule

/* dv/adaptive_threshold_binarizer_tb.sv */
module adaptive_threshold_binarizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import atb_pkg::*;

  localparam int MAX_W        = 2048;
  localparam int FRAC_BITS    = 16;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int TAIL_CYCLES  = 20;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             sof;
  } grey_item_t;

  typedef struct packed {
    logic                 is_white;
    logic [COL_OUT_W-1:0] column;
  } pixel_class_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] scan;
    logic                 odd;
    logic                 first;
  } scan_pos_t;

  localparam scan_pos_t IMAGE_START = '{scan: '0, odd: 1'b0, first: 1'b1};

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  atb_pix_if pix_ch ();
  atb_res_if res_ch ();

  adaptive_threshold_binarizer #(
    .MAX_WIDTH     (MAX_W),
    .SUM_FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register shadow
  logic [WIDTH_W-1:0] cfg_width = WIDTH_RST;
  logic [WLEN_W-1:0]  cfg_wlen  = WLEN_RST;
  logic [DECAY_W-1:0] cfg_decay = DECAY_RST;
  logic [PCT_W-1:0]   cfg_pct   = PCT_RST;

  // Scan and sum state as seen at each accepted pixel
  scan_pos_t        acc_pos = IMAGE_START;
  logic [SUM_W-1:0] run_sum = '0;
  logic [SUM_W-1:0] col_sums [MAX_W] = '{default: '0};

  // Scan state as seen when pixels are queued, to keep reads on written columns
  scan_pos_t gen_pos = IMAGE_START;
  bit        gen_written [MAX_W] = '{default: 1'b0};

  grey_item_t   grey_q [$];
  pixel_class_t class_q [$];
  grey_item_t   tx_item;
  pixel_class_t rx_want;

  int n_owed    = 0;
  int err_cnt   = 0;
  int cycle_cnt = 0;
  int tx_gap    = 0;
  int rx_stall  = 0;
  int grey_base = 128;
  bit tx_calm   = 1'b0;
  bit rx_calm   = 1'b0;

  always #4 clk = ~clk;

  function automatic int eff_width();
    int w;
    w = int'(cfg_width);
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic scan_pos_t clamp_scan(scan_pos_t p, int w);
    if (int'(p.scan) >= w) p.scan = COL_OUT_W'(w - 1);
    return p;
  endfunction

  function automatic int column_of(scan_pos_t p, int w);
    return p.odd ? (w - 1 - int'(p.scan)) : int'(p.scan);
  endfunction

  // Step the scan position; turn at the row end
  function automatic scan_pos_t next_pos(scan_pos_t p, int w);
    if (int'(p.scan) + 1 >= w) begin
      p.scan  = '0;
      p.odd   = ~p.odd;
      p.first = 1'b0;
    end else begin
      p.scan = p.scan + 1'b1;
    end
    return p;
  endfunction

  function automatic logic [SUM_W-1:0] sat32(logic [63:0] v);
    return (v > 64'(SUM_MAX)) ? SUM_MAX : v[SUM_W-1:0];
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int draw_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 85) return int'($urandom_range(3, 1));
    if (r < 97) return int'($urandom_range(12, 4));
    return int'($urandom_range(60, 20));
  endfunction

  // Drifting background with ink strokes, flat extremes and noise
  function automatic logic [PIX_W-1:0] next_grey();
    int r;
    int v;
    r = $urandom_range(99);
    grey_base = grey_base + int'($urandom_range(6)) - 3;
    if (grey_base < 0) grey_base = 0;
    if (grey_base > 255) grey_base = 255;
    if (r < 15) v = int'($urandom_range(255));
    else if (r < 22) v = (r < 18) ? 0 : 255;
    else if (r < 40) v = grey_base / 3;
    else v = grey_base + int'($urandom_range(16)) - 8;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[PIX_W-1:0];
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Compute the class of one accepted pixel and advance the sum state
  task automatic classify_pixel(input logic [PIX_W-1:0] px, input logic sof);
    int           w;
    int           col;
    logic [63:0]  total;
    logic [63:0]  twice;
    logic [63:0]  lhs;
    logic [63:0]  rhs;
    pixel_class_t verdict;
    w = eff_width();
    if (sof) begin
      acc_pos = IMAGE_START;
      run_sum = sat32((64'(SEED_LEVEL) * cfg_wlen) << FRAC_BITS);
    end
    acc_pos = clamp_scan(acc_pos, w);
    col = column_of(acc_pos, w);
    total = ((64'(run_sum) * cfg_decay) >> DECAY_W) + (64'(px) << FRAC_BITS);
    run_sum = sat32(total);
    twice = acc_pos.first ? (64'(run_sum) << 1) : (64'(run_sum) + 64'(col_sums[col]));
    col_sums[col] = run_sum;
    lhs = (64'(px) * cfg_wlen * PCT_SCALE) << FRAC_BITS;
    rhs = twice * cfg_pct;
    verdict.is_white = !(lhs < rhs);
    verdict.column = col[COL_OUT_W-1:0];
    class_q.push_back(verdict);
    acc_pos = next_pos(acc_pos, w);
  endtask

  // Queue one pixel; force an image start rather than read an unwritten column
  task automatic push_pixel(input logic [PIX_W-1:0] px, input logic sof);
    int        w;
    int        col;
    scan_pos_t p;
    w = eff_width();
    p = clamp_scan(sof ? IMAGE_START : gen_pos, w);
    col = column_of(p, w);
    if (!p.first && !gen_written[col]) begin
      sof = 1'b1;
      p = clamp_scan(IMAGE_START, w);
      col = column_of(p, w);
    end
    gen_written[col] = 1'b1;
    gen_pos = next_pos(p, w);
    grey_q.push_back('{pixel: px, sof: sof});
    n_owed++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_IMAGE_WIDTH:   cfg_width = val[WIDTH_W-1:0];
      REG_WINDOW_LEN:    cfg_wlen  = val[WLEN_W-1:0];
      REG_DECAY_COEFF:   cfg_decay = val[DECAY_W-1:0];
      REG_THRESHOLD_PCT: cfg_pct   = val[PCT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input int unsigned w, input int unsigned s,
                              input int unsigned d, input int unsigned p,
                              input logic [3:0] mask);
    if (mask[0]) write_reg(REG_IMAGE_WIDTH, w);
    if (mask[1]) write_reg(REG_WINDOW_LEN, s);
    if (mask[2]) write_reg(REG_DECAY_COEFF, d);
    if (mask[3]) write_reg(REG_THRESHOLD_PCT, p);
    if (mask != 4'd0) begin
      @(posedge clk);
      cfg_we <= 1'b0;
    end
  endtask

  // Hold until every queued pixel has come back, then let the pipe settle
  task automatic wait_idle();
    while (n_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_config();
    int unsigned w;
    int unsigned s;
    int unsigned d;
    int unsigned p;
    int          r;
    r = $urandom_range(99);
    if (r < 10) begin
      case ($urandom_range(3))
        0: w = 0;
        1: w = 1;
        2: w = 2048;
        default: w = 4095;
      endcase
    end else if (r < 55) w = $urandom_range(16, 2);
    else if (r < 90) w = $urandom_range(64, 17);
    else w = $urandom_range(300, 65);

    r = $urandom_range(99);
    if (r < 40) s = (w / 8 == 0) ? 1 : w / 8;
    else if (r < 55) begin
      case ($urandom_range(3))
        0: s = 0;
        1: s = 1;
        2: s = 256;
        default: s = 511;
      endcase
    end else if (r < 90) s = $urandom_range(256, 1);
    else s = $urandom_range(511, 257);

    r = $urandom_range(99);
    if (r < 50) d = (s == 0) ? 65535 : 65536 - 65536 / s;
    else if (r < 75) d = $urandom_range(65535);
    else begin
      case ($urandom_range(2))
        0: d = 0;
        1: d = 32768;
        default: d = 65535;
      endcase
    end
    if (d > 65535) d = 65535;

    r = $urandom_range(99);
    if (r < 45) p = $urandom_range(100);
    else if (r < 70) p = $urandom_range(75, 50);
    else if (r < 85) begin
      case ($urandom_range(2))
        0: p = 0;
        1: p = 100;
        default: p = 127;
      endcase
    end else p = $urandom_range(127);

    tx_calm = ($urandom_range(3) == 0);
    rx_calm = ($urandom_range(3) == 0);
    program_regs(w, s, d, p, 4'($urandom_range(15, 1)));
  endtask

  // Images with random content, a few stray start marks
  task automatic random_phase(input int n_items);
    push_pixel(next_grey(), $urandom_range(9) < 6);
    for (int i = 1; i < n_items; i++) begin
      push_pixel(next_grey(), $urandom_range(199) == 0);
    end
    wait_idle();
  endtask

  // Drive pixel transfers from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      pix_ch.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) classify_pixel(tx_item.pixel, tx_item.sof);
      if (!pix_ch.valid || pix_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          pix_ch.valid <= 1'b0;
        end else if (grey_q.size() > 0) begin
          tx_item = grey_q.pop_front();
          pix_ch.pixel          <= tx_item.pixel;
          pix_ch.start_of_image <= tx_item.sof;
          pix_ch.valid          <= 1'b1;
          tx_gap = tx_calm ? 0 : draw_gap();
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Check result transfers in order and stall the sink at random
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (class_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: white %0b column %0d",
                                  res_ch.is_white, res_ch.column));
        end else begin
          rx_want = class_q.pop_front();
          n_owed--;
          if (res_ch.is_white !== rx_want.is_white || res_ch.column !== rx_want.column)
            flag_mismatch($sformatf("got white %0b column %0d, want white %0b column %0d",
                                    res_ch.is_white, res_ch.column,
                                    rx_want.is_white, rx_want.column));
        end
      end
      if (rx_stall > 0) rx_stall--;
      else if (!rx_calm && $urandom_range(3) == 0) rx_stall = draw_gap();
      res_ch.ready <= (rx_stall == 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("adaptive_threshold_binarizer_tb: done, errors");
      $finish;
    end
  end

  initial begin
    pix_ch.valid          = 1'b0;
    pix_ch.pixel          = '0;
    pix_ch.start_of_image = 1'b0;
    res_ch.ready          = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = REG_IMAGE_WIDTH;
    cfg_data              = '0;
    rst                   = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // No start mark after reset: the sum grows from zero
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd10, 1'b0);
    wait_idle();

    // Narrow image: one even row, one odd row, then part of a third
    program_regs(4, 2, 32768, 100, 4'hF);
    push_pixel(8'd255, 1'b1);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd128, 1'b0);
    push_pixel(8'd64, 1'b0);
    push_pixel(8'd200, 1'b0);
    push_pixel(8'd50, 1'b0);
    wait_idle();

    // Width lowered mid-row, zero width, zero window, percent above 100
    program_regs(0, 0, 65535, 127, 4'hF);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd0, 1'b1);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd7, 1'b0);
    wait_idle();

    // Width above the line buffer, largest window: the sum saturates
    program_regs(4095, 511, 65535, 0, 4'hF);
    push_pixel(8'd255, 1'b1);
    repeat (5) push_pixel(8'd255, 1'b0);
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      random_config();
      random_phase(185);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("adaptive_threshold_binarizer_tb: done, clean");
    end else begin
      $display("adaptive_threshold_binarizer_tb: done, errors");
    end
    $finish;
  end

endmodule
